>>> rtl/ycbcr_color_window_region_counter_defines.svh
// Assertion macros for the color window region counter.
// Included by the top level; expects clk and rst_n in the including scope.
`ifndef YCBCR_COLOR_WINDOW_REGION_COUNTER_DEFINES_SVH
`define YCBCR_COLOR_WINDOW_REGION_COUNTER_DEFINES_SVH

`ifndef SYNTHESIS
`define YCWRC_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("ycwrc assertion failed");
`define YCWRC_ASSERT_MSG(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);
`else
`define YCWRC_ASSERT(label, prop)
`define YCWRC_ASSERT_MSG(label, prop, msg)
`endif

`endif

>>> rtl/ycwrc_pkg.sv
// Types, constants and helpers for the color window region counter.
// No dependencies; imported by ycwrc_classify and the top level.
package ycwrc_pkg;

    localparam int CNT_W       = 15;
    localparam int NUM_REGIONS = 7;

    typedef logic [CNT_W-1:0] count_t;

    localparam count_t CNT_MAX = {CNT_W{1'b1}};

    localparam logic [15:0] GREEN_BITS      = 16'h07E0;
    localparam logic [7:0]  DARK_LUMA       = 8'd20;
    localparam logic [6:0]  ROW_SPLIT_NEAR  = 7'd80;
    localparam logic [6:0]  ROW_SPLIT_FAR   = 7'd100;
    localparam logic [7:0]  COL_SPLIT_LEFT  = 8'd60;
    localparam logic [7:0]  COL_SPLIT_RIGHT = 8'd120;

    // conversion weights, sums kept in 17 bit signed
    localparam logic signed [16:0] Y_R    = 17'sd77;
    localparam logic signed [16:0] Y_G    = 17'sd150;
    localparam logic signed [16:0] Y_B    = 17'sd29;
    localparam logic signed [16:0] CB_R   = 17'sd43;
    localparam logic signed [16:0] CB_G   = 17'sd85;
    localparam logic signed [16:0] CR_G   = 17'sd107;
    localparam logic signed [16:0] CR_B   = 17'sd21;
    localparam logic signed [16:0] C_HALF = 17'sd128;

    typedef enum logic [2:0] {
        REGION_LOW_LEFT     = 3'd0,
        REGION_LOW_MID_NEAR = 3'd1,
        REGION_LOW_MID_FAR  = 3'd2,
        REGION_LOW_RIGHT    = 3'd3,
        REGION_HIGH_LEFT    = 3'd4,
        REGION_HIGH_MID     = 3'd5,
        REGION_HIGH_RIGHT   = 3'd6
    } region_t;

    typedef enum logic [2:0] {
        CFG_LUMA_LOW       = 3'd0,
        CFG_LUMA_HIGH      = 3'd1,
        CFG_BLUE_DIFF_LOW  = 3'd2,
        CFG_BLUE_DIFF_HIGH = 3'd3,
        CFG_RED_DIFF_LOW   = 3'd4,
        CFG_RED_DIFF_HIGH  = 3'd5,
        CFG_ROW_FIRST      = 3'd6,
        CFG_ROW_END        = 3'd7
    } cfg_index_t;

    typedef struct packed {
        logic [7:0] luma_low;
        logic [7:0] luma_high;
        logic [7:0] blue_diff_low;
        logic [7:0] blue_diff_high;
        logic [7:0] red_diff_low;
        logic [7:0] red_diff_high;
        logic [6:0] row_first;
        logic [6:0] row_end;
    } cfg_t;

    typedef struct packed {
        logic    match;
        logic    dark;
        region_t region;
    } class_t;

    function automatic count_t sat_inc(input count_t c);
        return (c == CNT_MAX) ? c : c + count_t'(1);
    endfunction

endpackage

>>> rtl/ycwrc_classify.sv
// Pixel classifier: RGB565 to Y/Cb/Cr, window tests and region select.
// Purely combinational; uses ycwrc_pkg.
module ycwrc_classify
    import ycwrc_pkg::*;
#(
    parameter int FRAME_WIDTH  = 180,
    parameter int FRAME_HEIGHT = 120
)
(
    input  logic [15:0] pixel,
    input  logic [6:0]  row,
    input  logic [7:0]  column,
    input  cfg_t        cfg,
    output class_t      cls
);

    logic signed [16:0] r_s;
    logic signed [16:0] g_s;
    logic signed [16:0] b_s;
    logic signed [16:0] y_sum;
    logic signed [16:0] cb_sum;
    logic signed [16:0] cr_sum;
    logic [7:0]         luma;
    logic signed [7:0]  cb;
    logic signed [7:0]  cr;
    logic               examine;
    logic               chroma_ok;
    logic               luma_ok;

    // channels widened to 8 bits by a left shift
    assign r_s = signed'({9'd0, pixel[15:11], 3'd0});
    assign g_s = signed'({9'd0, pixel[10:5], 2'd0});
    assign b_s = signed'({9'd0, pixel[4:0], 3'd0});

    assign y_sum  = Y_R * r_s + Y_G * g_s + Y_B * b_s + C_HALF;
    assign cb_sum = C_HALF * b_s - CB_R * r_s - CB_G * g_s - C_HALF;
    assign cr_sum = C_HALF * r_s - CR_G * g_s - CR_B * b_s - C_HALF;

    // Y sum is non-negative and below 2^16, chroma sums fit 16 bit two's complement,
    // so bits 15:8 are the floor shift
    assign luma = y_sum[15:8];
    assign cb   = signed'(cb_sum[15:8]);
    assign cr   = signed'(cr_sum[15:8]);

    assign examine = (row >= cfg.row_first) && (row < cfg.row_end)
                  && (32'(row) < FRAME_HEIGHT) && (32'(column) < FRAME_WIDTH);

    assign chroma_ok = (cb >= signed'(cfg.blue_diff_low)) && (cb <= signed'(cfg.blue_diff_high))
                    && (cr >= signed'(cfg.red_diff_low)) && (cr <= signed'(cfg.red_diff_high));

    assign luma_ok = (luma >= cfg.luma_low) && (luma <= cfg.luma_high);

    always_comb
    begin
        cls.match = examine && chroma_ok && luma_ok;
        cls.dark  = examine && chroma_ok && !luma_ok && (luma <= DARK_LUMA);

        priority if (row >= ROW_SPLIT_NEAR)
        begin
            priority if (column < COL_SPLIT_LEFT)
                cls.region = REGION_LOW_LEFT;
            else if (column < COL_SPLIT_RIGHT)
                cls.region = (row < ROW_SPLIT_FAR) ? REGION_LOW_MID_NEAR : REGION_LOW_MID_FAR;
            else
                cls.region = REGION_LOW_RIGHT;
        end
        else
        begin
            priority if (column < COL_SPLIT_LEFT)
                cls.region = REGION_HIGH_LEFT;
            else if (column < COL_SPLIT_RIGHT)
                cls.region = REGION_HIGH_MID;
            else
                cls.region = REGION_HIGH_RIGHT;
        end
    end

endmodule

>>> rtl/ycbcr_color_window_region_counter.sv
// Channel   | Handshake                   | Payload
// input     | in_valid / in_stall         | pixel_in, row, column, clear_counts
// output    | out_valid / out_stall       | pixel_out, is_match, is_dark, count_*
// config    | cfg_valid / cfg_ready       | cfg_index, cfg_data
// One pixel per cycle while out_stall is low; the path is the input register, then the
// classifier and counter update into the result register.
// Counters are the result register: they move only when a transaction enters it.
// Reset loads the default windows and zeroes every counter; cfg_ready is always high.
// out_stall with a full result register holds it; in_stall rises once the input
// register is also full.
// Depends on ycwrc_pkg, ycwrc_classify and the defines header.
`include "ycbcr_color_window_region_counter_defines.svh"

module ycbcr_color_window_region_counter
    import ycwrc_pkg::*;
#(
    parameter int FRAME_WIDTH  = 180,
    parameter int FRAME_HEIGHT = 120
)
(
    input  logic         clk,
    input  logic         rst_n,

    input  logic         in_valid,
    output logic         in_stall,
    input  logic [15:0]  pixel_in,
    input  logic [6:0]   row,
    input  logic [7:0]   column,
    input  logic         clear_counts,

    output logic         out_valid,
    input  logic         out_stall,
    output logic [15:0]  pixel_out,
    output logic         is_match,
    output logic         is_dark,
    output logic [14:0]  count_low_left,
    output logic [14:0]  count_low_mid_near,
    output logic [14:0]  count_low_mid_far,
    output logic [14:0]  count_low_right,
    output logic [14:0]  count_high_left,
    output logic [14:0]  count_high_mid,
    output logic [14:0]  count_high_right,
    output logic [14:0]  count_dark,

    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [2:0]   cfg_index,
    input  logic [7:0]   cfg_data
);

    cfg_t        cfg_reg;

    logic        s1_valid_reg;
    logic [15:0] s1_pixel_reg;
    logic [6:0]  s1_row_reg;
    logic [7:0]  s1_column_reg;
    logic        s1_clear_reg;

    logic        out_valid_reg;
    logic [15:0] pixel_out_reg;
    logic        is_match_reg;
    logic        is_dark_reg;
    count_t      count_reg [NUM_REGIONS];
    count_t      count_dark_reg;

    count_t      count_next [NUM_REGIONS];
    count_t      count_dark_next;
    logic [15:0] pixel_out_next;

    logic        s2_adv;
    logic        s1_load;
    logic        s2_take;
    class_t      cls;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.luma_low       <= 8'd70;
            cfg_reg.luma_high      <= 8'd140;
            cfg_reg.blue_diff_low  <= 8'hF6;
            cfg_reg.blue_diff_high <= 8'h0A;
            cfg_reg.red_diff_low   <= 8'hF6;
            cfg_reg.red_diff_high  <= 8'h0A;
            cfg_reg.row_first      <= 7'd60;
            cfg_reg.row_end        <= 7'd120;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_LUMA_LOW:       cfg_reg.luma_low       <= cfg_data;
                CFG_LUMA_HIGH:      cfg_reg.luma_high      <= cfg_data;
                CFG_BLUE_DIFF_LOW:  cfg_reg.blue_diff_low  <= cfg_data;
                CFG_BLUE_DIFF_HIGH: cfg_reg.blue_diff_high <= cfg_data;
                CFG_RED_DIFF_LOW:   cfg_reg.red_diff_low   <= cfg_data;
                CFG_RED_DIFF_HIGH:  cfg_reg.red_diff_high  <= cfg_data;
                CFG_ROW_FIRST:      cfg_reg.row_first      <= cfg_data[6:0];
                CFG_ROW_END:        cfg_reg.row_end        <= cfg_data[6:0];
            endcase
        end
    end

    // flow control: result register frees when empty or taken
    assign s2_adv   = !out_valid_reg || !out_stall;
    assign in_stall = s1_valid_reg && !s2_adv;
    assign s1_load  = in_valid && !in_stall;
    assign s2_take  = s2_adv && s1_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (!in_stall)
            s1_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            s1_pixel_reg  <= pixel_in;
            s1_row_reg    <= row;
            s1_column_reg <= column;
            s1_clear_reg  <= clear_counts;
        end
    end

    ycwrc_classify #(
        .FRAME_WIDTH  (FRAME_WIDTH),
        .FRAME_HEIGHT (FRAME_HEIGHT)
    ) u_classify (
        .pixel  (s1_pixel_reg),
        .row    (s1_row_reg),
        .column (s1_column_reg),
        .cfg    (cfg_reg),
        .cls    (cls)
    );

    always_comb
    begin
        count_t base;
        for (int k = 0; k < NUM_REGIONS; k++)
        begin
            base = s1_clear_reg ? '0 : count_reg[k];
            count_next[k] = (cls.match && (cls.region == region_t'(3'(k))))
                          ? sat_inc(base) : base;
        end
        base = s1_clear_reg ? '0 : count_dark_reg;
        count_dark_next = cls.dark ? sat_inc(base) : base;
        pixel_out_next  = cls.match ? (s1_pixel_reg | GREEN_BITS) : s1_pixel_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            count_dark_reg <= '0;
            for (int k = 0; k < NUM_REGIONS; k++)
                count_reg[k] <= '0;
        end
        else if (s2_adv)
        begin
            out_valid_reg <= s1_valid_reg;
            if (s1_valid_reg)
            begin
                count_dark_reg <= count_dark_next;
                for (int k = 0; k < NUM_REGIONS; k++)
                    count_reg[k] <= count_next[k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_take)
        begin
            pixel_out_reg <= pixel_out_next;
            is_match_reg  <= cls.match;
            is_dark_reg   <= cls.dark;
        end
    end

    assign out_valid          = out_valid_reg;
    assign pixel_out          = pixel_out_reg;
    assign is_match           = is_match_reg;
    assign is_dark            = is_dark_reg;
    assign count_low_left     = count_reg[REGION_LOW_LEFT];
    assign count_low_mid_near = count_reg[REGION_LOW_MID_NEAR];
    assign count_low_mid_far  = count_reg[REGION_LOW_MID_FAR];
    assign count_low_right    = count_reg[REGION_LOW_RIGHT];
    assign count_high_left    = count_reg[REGION_HIGH_LEFT];
    assign count_high_mid     = count_reg[REGION_HIGH_MID];
    assign count_high_right   = count_reg[REGION_HIGH_RIGHT];
    assign count_dark         = count_dark_reg;

    `YCWRC_ASSERT_MSG(a_match_dark_excl, out_valid_reg |-> !(is_match_reg && is_dark_reg), "match and dark both set")
    `YCWRC_ASSERT(a_match_green, (out_valid_reg && is_match_reg) |-> ((pixel_out_reg & GREEN_BITS) == GREEN_BITS))
    `YCWRC_ASSERT(a_dark_counted, (out_valid_reg && is_dark_reg) |-> (count_dark_reg != '0))
    `YCWRC_ASSERT_MSG(a_counts_hold, !s2_take |=> $stable(count_dark_reg), "dark counter moved without a transaction")
    `YCWRC_ASSERT(a_stall_full, in_stall |-> (s1_valid_reg && out_valid_reg))

endmodule

>>> dv/region_count_checker.sv
// Checker for the color window region counter: predicts every result transaction
// from the pixel and config transactions it observes, then compares field by field.
// Depends on ycwrc_pkg for the count type, region codes and register indexes.
module region_count_checker
    import ycwrc_pkg::*;
#(
    parameter int FRAME_WIDTH  = 180,
    parameter int FRAME_HEIGHT = 120
)
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [15:0] pixel_in,
    input  logic [6:0]  row,
    input  logic [7:0]  column,
    input  logic        clear_counts,

    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [15:0] pixel_out,
    input  logic        is_match,
    input  logic        is_dark,
    input  logic [14:0] count_low_left,
    input  logic [14:0] count_low_mid_near,
    input  logic [14:0] count_low_mid_far,
    input  logic [14:0] count_low_right,
    input  logic [14:0] count_high_left,
    input  logic [14:0] count_high_mid,
    input  logic [14:0] count_high_right,
    input  logic [14:0] count_dark,

    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [7:0]  cfg_data,

    output int          failures,
    output int          pending,
    output int          checked,
    output int          matched,
    output int          darkened
);

    localparam int NUM_COUNTS = NUM_REGIONS + 1;
    localparam int DARK_SLOT  = NUM_REGIONS;

    typedef struct packed {
        logic [15:0]                 pixel;
        logic                        match;
        logic                        dark;
        count_t [NUM_COUNTS-1:0]     counts;
    } pixel_result_t;

    pixel_result_t           expected_pixels[$];
    pixel_result_t           exp_res;
    pixel_result_t           act_res;
    count_t [NUM_COUNTS-1:0] tally;
    int                      luma_lo;
    int                      luma_hi;
    int                      cb_lo;
    int                      cb_hi;
    int                      cr_lo;
    int                      cr_hi;
    int                      row_lo;
    int                      row_hi;

    string count_names[NUM_COUNTS] = '{
        "count_low_left", "count_low_mid_near", "count_low_mid_far", "count_low_right",
        "count_high_left", "count_high_mid", "count_high_right", "count_dark"
    };

    initial
    begin
        failures = 0;
        pending  = 0;
        checked  = 0;
        matched  = 0;
        darkened = 0;
    end

    // Updates the tally and returns what the block should emit for this pixel.
    function automatic pixel_result_t classify_pixel(input logic [15:0] pix,
                                                     input logic [6:0] r,
                                                     input logic [7:0] c,
                                                     input logic clr);
        pixel_result_t res;
        int            red;
        int            grn;
        int            blu;
        int            y;
        int            cb;
        int            cr;
        int            slot;
        logic          chroma_ok;
        region_t       region;

        res = '0;
        res.pixel = pix;
        slot = -1;
        if (clr)
            tally = '0;
        if (r >= row_lo && r < row_hi && r < FRAME_HEIGHT && c < FRAME_WIDTH)
        begin
            red = int'(pix[15:11]) * 8;
            grn = int'(pix[10:5]) * 4;
            blu = int'(pix[4:0]) * 8;
            // >>> on int rounds toward minus infinity
            y  = (77 * red + 150 * grn + 29 * blu + 128) >>> 8;
            cb = (-43 * red - 85 * grn + 128 * blu - 128) >>> 8;
            cr = (128 * red - 107 * grn - 21 * blu - 128) >>> 8;
            chroma_ok = cb >= cb_lo && cb <= cb_hi && cr >= cr_lo && cr <= cr_hi;
            if (chroma_ok && y >= luma_lo && y <= luma_hi)
            begin
                res.match = 1'b1;
                res.pixel = pix | GREEN_BITS;
                if (r >= ROW_SPLIT_NEAR)
                begin
                    if (c < COL_SPLIT_LEFT)
                        region = REGION_LOW_LEFT;
                    else if (c < COL_SPLIT_RIGHT)
                        region = (r < ROW_SPLIT_FAR) ? REGION_LOW_MID_NEAR : REGION_LOW_MID_FAR;
                    else
                        region = REGION_LOW_RIGHT;
                end
                else
                begin
                    if (c < COL_SPLIT_LEFT)
                        region = REGION_HIGH_LEFT;
                    else if (c < COL_SPLIT_RIGHT)
                        region = REGION_HIGH_MID;
                    else
                        region = REGION_HIGH_RIGHT;
                end
                slot = int'(region);
            end
            else if (chroma_ok && y <= int'(DARK_LUMA))
            begin
                res.dark = 1'b1;
                slot = DARK_SLOT;
            end
        end
        if (slot >= 0 && tally[slot] != CNT_MAX)
            tally[slot] = tally[slot] + 1'b1;
        res.counts = tally;
        return res;
    endfunction

    task automatic compare_field(input string field, input logic [15:0] want,
                                 input logic [15:0] got);
        if (want !== got)
        begin
            failures++;
            if (failures <= 10)
                $display("mismatch on %s in result %0d: expected %0d, got %0d",
                         field, checked, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_pixels.delete();
            tally   = '0;
            luma_lo = 70;
            luma_hi = 140;
            cb_lo   = -10;
            cb_hi   = 10;
            cr_lo   = -10;
            cr_hi   = 10;
            row_lo  = 60;
            row_hi  = 120;
            pending = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_pixels.size() == 0)
                begin
                    failures++;
                    if (failures <= 10)
                        $display("result transaction with nothing expected: pixel_out %h",
                                 pixel_out);
                end
                else
                begin
                    exp_res = expected_pixels.pop_front();
                    act_res.pixel  = pixel_out;
                    act_res.match  = is_match;
                    act_res.dark   = is_dark;
                    act_res.counts = {count_dark, count_high_right, count_high_mid,
                                      count_high_left, count_low_right, count_low_mid_far,
                                      count_low_mid_near, count_low_left};
                    compare_field("pixel_out", exp_res.pixel, act_res.pixel);
                    compare_field("is_match", 16'(exp_res.match), 16'(act_res.match));
                    compare_field("is_dark", 16'(exp_res.dark), 16'(act_res.dark));
                    for (int i = 0; i < NUM_COUNTS; i++)
                        compare_field(count_names[i], 16'(exp_res.counts[i]),
                                      16'(act_res.counts[i]));
                    checked++;
                    if (exp_res.match)
                        matched++;
                    if (exp_res.dark)
                        darkened++;
                end
            end

            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index_t'(cfg_index))
                    CFG_LUMA_LOW:       luma_lo = int'(cfg_data);
                    CFG_LUMA_HIGH:      luma_hi = int'(cfg_data);
                    CFG_BLUE_DIFF_LOW:  cb_lo   = int'($signed(cfg_data));
                    CFG_BLUE_DIFF_HIGH: cb_hi   = int'($signed(cfg_data));
                    CFG_RED_DIFF_LOW:   cr_lo   = int'($signed(cfg_data));
                    CFG_RED_DIFF_HIGH:  cr_hi   = int'($signed(cfg_data));
                    CFG_ROW_FIRST:      row_lo  = int'(cfg_data[6:0]);
                    CFG_ROW_END:        row_hi  = int'(cfg_data[6:0]);
                    default: ;
                endcase
            end

            if (in_valid && !in_stall)
                expected_pixels.push_back(classify_pixel(pixel_in, row, column, clear_counts));

            pending = expected_pixels.size();
        end
    end

endmodule

>>> dv/testbench.sv
// Top of the color window region counter testbench: clock, reset, pixel and
// config stimulus, output stalls and the verdict.
// Depends on ycwrc_pkg, the block and region_count_checker.
module testbench;
    import ycwrc_pkg::*;

    localparam int FRAME_WIDTH   = 180;
    localparam int FRAME_HEIGHT  = 120;
    localparam int PHASE_ITEMS   = 130;
    localparam int REGION_ROUNDS = 4;   // sweeps through every region and the dark counter
    localparam int LIMIT_CYCLES  = 2_000_000;

    localparam logic [15:0] GRAY_PIXEL  = 16'h8410;   // Y 128, Cb -1, Cr -1
    localparam logic [15:0] BLACK_PIXEL = 16'h0000;   // Y 0, Cb -1, Cr -1

    localparam cfg_t DEFAULT_WINDOWS = '{
        luma_low: 8'd70, luma_high: 8'd140,
        blue_diff_low: -8'sd10, blue_diff_high: 8'sd10,
        red_diff_low: -8'sd10, red_diff_high: 8'sd10,
        row_first: 7'd60, row_end: 7'd120
    };

    logic        clk;
    logic        rst_n        = 1'b0;
    logic        in_valid     = 1'b0;
    logic        in_stall;
    logic [15:0] pixel_in     = '0;
    logic [6:0]  row          = '0;
    logic [7:0]  column       = '0;
    logic        clear_counts = 1'b0;
    logic        out_valid;
    logic        out_stall    = 1'b0;
    logic [15:0] pixel_out;
    logic        is_match;
    logic        is_dark;
    logic [14:0] count_low_left;
    logic [14:0] count_low_mid_near;
    logic [14:0] count_low_mid_far;
    logic [14:0] count_low_right;
    logic [14:0] count_high_left;
    logic [14:0] count_high_mid;
    logic [14:0] count_high_right;
    logic [14:0] count_dark;
    logic        cfg_valid    = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index    = CFG_LUMA_LOW;
    logic [7:0]  cfg_data     = '0;

    int failures;
    int pending;
    int checked;
    int matched;
    int darkened;
    int send_idle_pct  = 0;
    int stall_pct      = 0;
    int pixels_sent    = 0;
    int settings_used  = 0;

    ycbcr_color_window_region_counter #(
        .FRAME_WIDTH  (FRAME_WIDTH),
        .FRAME_HEIGHT (FRAME_HEIGHT)
    ) u_top (.*);

    region_count_checker #(
        .FRAME_WIDTH  (FRAME_WIDTH),
        .FRAME_HEIGHT (FRAME_HEIGHT)
    ) u_checker (.*);

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #(LIMIT_CYCLES * 20);
        $display("RESULT: ERROR");
        $finish;
    end

    always @(negedge clk)
        out_stall <= ($urandom_range(99) < stall_pct);

    function automatic int clamp(input int v, input int hi);
        return (v < 0) ? 0 : (v > hi) ? hi : v;
    endfunction

    // Mostly near-gray pixels, since those are the ones that land in the chroma windows.
    function automatic logic [15:0] random_pixel();
        int v;
        int r5;
        int g6;
        int b5;
        if ($urandom_range(99) < 40)
            return 16'($urandom);
        v  = $urandom_range(0, 31);
        r5 = clamp(v + int'($urandom_range(0, 4)) - 2, 31);
        g6 = clamp(2 * v + int'($urandom_range(0, 8)) - 4, 63);
        b5 = clamp(v + int'($urandom_range(0, 4)) - 2, 31);
        return {r5[4:0], g6[5:0], b5[4:0]};
    endfunction

    function automatic cfg_t random_settings();
        cfg_t s;
        if ($urandom_range(3) == 0)
        begin
            s = cfg_t'(62'({$urandom, $urandom}));
            s.row_first = 7'($urandom_range(0, 120));
            s.row_end   = 7'($urandom_range(0, 120));
            return s;
        end
        s.luma_low       = 8'($urandom_range(0, 150));
        s.luma_high      = 8'(s.luma_low + $urandom_range(0, 105));
        s.blue_diff_low  = 8'(0 - $urandom_range(0, 40));
        s.blue_diff_high = 8'($urandom_range(0, 40));
        s.red_diff_low   = 8'(0 - $urandom_range(0, 40));
        s.red_diff_high  = 8'($urandom_range(0, 40));
        s.row_first      = 7'($urandom_range(0, 100));
        s.row_end        = 7'($urandom_range(s.row_first, 120));
        return s;
    endfunction

    // Called at a falling edge; returns at the falling edge after the transaction.
    task automatic send_pixel(input logic [15:0] pix, input logic [6:0] r,
                              input logic [7:0] c, input logic clr);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid     <= 1'b1;
        pixel_in     <= pix;
        row          <= r;
        column       <= c;
        clear_counts <= clr;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pixels_sent++;
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
    endtask

    task automatic apply_settings(input cfg_t s);
        cfg_index_t idx;
        idx = idx.first();
        do
        begin
            cfg_valid <= 1'b1;
            cfg_index <= idx;
            case (idx)
                CFG_LUMA_LOW:       cfg_data <= s.luma_low;
                CFG_LUMA_HIGH:      cfg_data <= s.luma_high;
                CFG_BLUE_DIFF_LOW:  cfg_data <= s.blue_diff_low;
                CFG_BLUE_DIFF_HIGH: cfg_data <= s.blue_diff_high;
                CFG_RED_DIFF_LOW:   cfg_data <= s.red_diff_low;
                CFG_RED_DIFF_HIGH:  cfg_data <= s.red_diff_high;
                CFG_ROW_FIRST:      cfg_data <= {1'b0, s.row_first};
                CFG_ROW_END:        cfg_data <= {1'b0, s.row_end};
                default: ;
            endcase
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
            @(negedge clk);
            idx = idx.next();
        end
        while (idx != idx.first());
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    initial
    begin
        cfg_t       phase_settings[$];
        logic [6:0] r;
        logic [7:0] c;
        logic [15:0] pix;

        phase_settings.push_back('{luma_low: 8'd0, luma_high: 8'd255,
            blue_diff_low: 8'h80, blue_diff_high: 8'h7F,
            red_diff_low: 8'h80, red_diff_high: 8'h7F,
            row_first: 7'd0, row_end: 7'd120});
        // reversed luma window with open chroma: nothing matches, dark pixels still count
        phase_settings.push_back('{luma_low: 8'd255, luma_high: 8'd0,
            blue_diff_low: 8'h80, blue_diff_high: 8'h7F,
            red_diff_low: 8'h80, red_diff_high: 8'h7F,
            row_first: 7'd0, row_end: 7'd120});
        phase_settings.push_back('{luma_low: 8'd0, luma_high: 8'd255,
            blue_diff_low: 8'sd10, blue_diff_high: -8'sd10,
            red_diff_low: 8'h80, red_diff_high: 8'h7F,
            row_first: 7'd0, row_end: 7'd120});
        phase_settings.push_back('{luma_low: 8'd0, luma_high: 8'd255,
            blue_diff_low: 8'h80, blue_diff_high: 8'h7F,
            red_diff_low: 8'h80, red_diff_high: 8'h7F,
            row_first: 7'd120, row_end: 7'd0});
        phase_settings.push_back('{luma_low: 8'd0, luma_high: 8'd255,
            blue_diff_low: 8'h80, blue_diff_high: 8'h7F,
            red_diff_low: 8'h80, red_diff_high: 8'h7F,
            row_first: 7'd50, row_end: 7'd50});
        phase_settings.push_back(DEFAULT_WINDOWS);
        repeat (4)
            phase_settings.push_back(random_settings());

        repeat (3)
            @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed pixels against the reset windows
        send_pixel(BLACK_PIXEL, 7'd60, 8'd0, 1'b0);
        send_pixel(16'hFFFF, 7'd119, 8'd179, 1'b0);
        send_pixel(GRAY_PIXEL, 7'd80, 8'd59, 1'b0);
        send_pixel(GRAY_PIXEL, 7'd80, 8'd60, 1'b0);
        send_pixel(GRAY_PIXEL, 7'd99, 8'd119, 1'b0);
        send_pixel(GRAY_PIXEL, 7'd100, 8'd60, 1'b0);
        send_pixel(GRAY_PIXEL, 7'd119, 8'd120, 1'b0);
        send_pixel(GRAY_PIXEL, 7'd79, 8'd0, 1'b0);
        send_pixel(GRAY_PIXEL, 7'd79, 8'd60, 1'b0);
        send_pixel(GRAY_PIXEL, 7'd60, 8'd179, 1'b0);
        send_pixel(GRAY_PIXEL, 7'd59, 8'd10, 1'b0);
        send_pixel(GRAY_PIXEL, 7'd120, 8'd10, 1'b0);
        send_pixel(GRAY_PIXEL, 7'd127, 8'd10, 1'b0);
        send_pixel(GRAY_PIXEL, 7'd70, 8'd180, 1'b0);
        send_pixel(GRAY_PIXEL, 7'd70, 8'd255, 1'b0);
        send_pixel(16'hF800, 7'd70, 8'd5, 1'b0);
        send_pixel(16'h07E0, 7'd70, 8'd5, 1'b0);
        send_pixel(16'h001F, 7'd70, 8'd5, 1'b0);
        send_pixel(GRAY_PIXEL, 7'd70, 8'd70, 1'b1);
        send_pixel(BLACK_PIXEL, 7'd100, 8'd100, 1'b1);
        send_pixel(BLACK_PIXEL, 7'd0, 8'd0, 1'b0);
        drain();

        for (int phase = 0; phase < phase_settings.size(); phase++)
        begin
            case (phase % 4)
                0:       begin send_idle_pct = 0;  stall_pct = 0;  end
                1:       begin send_idle_pct = 74; stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  stall_pct = 74; end
                default: begin send_idle_pct = 23; stall_pct = 23; end
            endcase
            apply_settings(phase_settings[phase]);
            repeat (PHASE_ITEMS)
            begin
                pix = random_pixel();
                r = ($urandom_range(99) < 10) ? 7'($urandom) : 7'($urandom_range(0, 119));
                c = ($urandom_range(99) < 10) ? 8'($urandom) : 8'($urandom_range(0, 179));
                send_pixel(pix, r, c, $urandom_range(99) < 3);
            end
            drain();
        end

        // sweep every region counter and the dark counter at full rate
        send_idle_pct = 0;
        stall_pct     = 0;
        apply_settings(DEFAULT_WINDOWS);
        send_pixel(BLACK_PIXEL, 7'd0, 8'd0, 1'b1);
        repeat (REGION_ROUNDS)
        begin
            for (int kind = 0; kind <= NUM_REGIONS; kind++)
            begin
                pix = GRAY_PIXEL;
                if (kind == NUM_REGIONS)
                begin
                    pix = BLACK_PIXEL;
                    r = 7'($urandom_range(60, 119));
                    c = 8'($urandom_range(0, 179));
                end
                else
                begin
                    case (region_t'(kind))
                        REGION_LOW_LEFT:     begin r = 7'($urandom_range(80, 119));
                                                   c = 8'($urandom_range(0, 59));    end
                        REGION_LOW_MID_NEAR: begin r = 7'($urandom_range(80, 99));
                                                   c = 8'($urandom_range(60, 119));  end
                        REGION_LOW_MID_FAR:  begin r = 7'($urandom_range(100, 119));
                                                   c = 8'($urandom_range(60, 119));  end
                        REGION_LOW_RIGHT:    begin r = 7'($urandom_range(80, 119));
                                                   c = 8'($urandom_range(120, 179)); end
                        REGION_HIGH_LEFT:    begin r = 7'($urandom_range(60, 79));
                                                   c = 8'($urandom_range(0, 59));    end
                        REGION_HIGH_MID:     begin r = 7'($urandom_range(60, 79));
                                                   c = 8'($urandom_range(60, 119));  end
                        default:             begin r = 7'($urandom_range(60, 79));
                                                   c = 8'($urandom_range(120, 179)); end
                    endcase
                end
                send_pixel(pix, r, c, 1'b0);
            end
        end
        // clear with a pixel, with a stalled receiver
        stall_pct = 74;
        send_pixel(GRAY_PIXEL, 7'd60, 8'd0, 1'b1);
        send_pixel(BLACK_PIXEL, 7'd61, 8'd1, 1'b0);
        drain();
        repeat (4)
            @(negedge clk);

        $display("sent %0d pixel transactions under %0d window settings, every counter hit",
                 pixels_sent, settings_used);
        $display("checked %0d results: %0d matches, %0d dark, %0d failures",
                 checked, matched, darkened, failures);
        if (failures == 0 && pending == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
